// File: rtl/core/rvex_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the Euler XYZ rotator.
// No dependencies; every other file of the core imports this package.
`timescale 1ns / 1ps
package rvex_pkg;

    // Field widths and iteration count
    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;

    // Internal widths: coordinates get guard bits, trig values are Q2.30
    localparam int WIDE_W    = COORD_WIDTH + 4;
    localparam int TRIG_W    = 32;
    localparam int CX_W      = 33;
    localparam int CZ_W      = 35;
    localparam int PROD_W    = WIDE_W + TRIG_W;
    localparam int ANG_SHIFT = 33 - ANGLE_WIDTH;

    // Sine/cosine pipeline depth: wrap, fold, one stage per step, sign fix
    localparam int SC_LAT = CORDIC_STEPS + 3;

    // Queue depths and their pointer and count widths
    localparam int MID_DEPTH = 32;
    localparam int OUT_DEPTH = 16;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Angle constants in Q30 radians
    localparam logic signed [CZ_W-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [CZ_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [CX_W-1:0] GAIN_Q30    = 33'sd652032874;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic signed [COORD_WIDTH-1:0] coord_z;
        logic signed [ANGLE_WIDTH-1:0] pitch_angle;
        logic signed [ANGLE_WIDTH-1:0] yaw_angle;
        logic signed [ANGLE_WIDTH-1:0] roll_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] rotated_x;
        logic signed [COORD_WIDTH-1:0] rotated_y;
        logic signed [COORD_WIDTH-1:0] rotated_z;
        logic                          saturated;
    } t_out_item;

    typedef struct packed {
        logic                     skip;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cs;
    } t_trig;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic signed [COORD_WIDTH-1:0] coord_z;
        t_trig                         pitch_trig;
        t_trig                         yaw_trig;
        t_trig                         roll_trig;
    } t_mid_item;

    // atan(2^-i) rounded to Q30
    function automatic logic signed [CZ_W-1:0] atan_q30(input int idx);
        logic signed [CZ_W-1:0] v;
        unique case (idx)
            0:  v = 35'sd843314857;
            1:  v = 35'sd497837829;
            2:  v = 35'sd263043837;
            3:  v = 35'sd133525159;
            4:  v = 35'sd67021687;
            5:  v = 35'sd33543516;
            6:  v = 35'sd16775851;
            7:  v = 35'sd8388437;
            8:  v = 35'sd4194283;
            9:  v = 35'sd2097149;
            10: v = 35'sd1048576;
            11: v = 35'sd524288;
            12: v = 35'sd262144;
            13: v = 35'sd131072;
            14: v = 35'sd65536;
            15: v = 35'sd32768;
            16: v = 35'sd16384;
            17: v = 35'sd8192;
            18: v = 35'sd4096;
            19: v = 35'sd2048;
            20: v = 35'sd1024;
            21: v = 35'sd512;
            22: v = 35'sd256;
            23: v = 35'sd128;
            24: v = 35'sd64;
            25: v = 35'sd32;
            26: v = 35'sd16;
            27: v = 35'sd8;
            28: v = 35'sd4;
            29: v = 35'sd2;
            30: v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/rvex_sincos.sv
// Pipelined CORDIC sine/cosine for one Q3.13 angle, with range reduction.
// Depends on rvex_pkg; free-running, with no reset or stall.
`timescale 1ns / 1ps
module rvex_sincos (
    input  logic                                   i_clk,
    input  logic signed [rvex_pkg::ANGLE_WIDTH-1:0] i_angle,
    output rvex_pkg::t_trig                        o_trig
);
    import rvex_pkg::*;

    logic signed [CZ_W-1:0] z_full;
    logic signed [CZ_W-1:0] n_wrap;
    logic signed [CZ_W-1:0] r_wrap;
    logic                   r_wrap_skip;
    logic signed [CZ_W-1:0] n_fold;
    logic                   n_flip;

    logic signed [CX_W-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [CX_W-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] r_z    [0:CORDIC_STEPS];
    logic                   r_flip [0:CORDIC_STEPS];
    logic                   r_skip [0:CORDIC_STEPS];
    t_trig                  r_trig;

    // Scale to Q30 and wrap into [-pi, pi]
    always_comb begin
        z_full = CZ_W'(i_angle) <<< ANG_SHIFT;
        if (z_full > PI_Q30) begin
            n_wrap = z_full - TWO_PI_Q30;
        end else if (z_full < -PI_Q30) begin
            n_wrap = z_full + TWO_PI_Q30;
        end else begin
            n_wrap = z_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wrap      <= n_wrap;
        r_wrap_skip <= (i_angle == '0);
    end

    // Fold into [-pi/2, pi/2] and note the sign flip
    always_comb begin
        if (r_wrap > HALF_PI_Q30) begin
            n_fold = r_wrap - PI_Q30;
            n_flip = 1'b1;
        end else if (r_wrap < -HALF_PI_Q30) begin
            n_fold = r_wrap + PI_Q30;
            n_flip = 1'b1;
        end else begin
            n_fold = r_wrap;
            n_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= GAIN_Q30;
        r_y[0]    <= '0;
        r_z[0]    <= n_fold;
        r_flip[0] <= n_flip;
        r_skip[0] <= r_wrap_skip;
    end

    // One rotation step per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_q30(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_q30(i);
            end
            r_flip[i+1] <= r_flip[i];
            r_skip[i+1] <= r_skip[i];
        end
    end

    // Undo the fold by negating both results
    always_ff @(posedge i_clk) begin
        r_trig.skip <= r_skip[CORDIC_STEPS];
        if (r_flip[CORDIC_STEPS]) begin
            r_trig.sn <= TRIG_W'(-r_y[CORDIC_STEPS]);
            r_trig.cs <= TRIG_W'(-r_x[CORDIC_STEPS]);
        end else begin
            r_trig.sn <= TRIG_W'(r_y[CORDIC_STEPS]);
            r_trig.cs <= TRIG_W'(r_x[CORDIC_STEPS]);
        end
    end

    assign o_trig = r_trig;

endmodule

// File: rtl/core/rvex_front.sv
// Front end: accepts transactions and computes sine/cosine of all three angles.
// Depends on rvex_pkg and rvex_sincos; holds admission credits for the middle queue.
`timescale 1ns / 1ps
module rvex_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  rvex_pkg::t_in_item  i_item,
    input  logic                i_q_pop,
    output logic                o_q_push,
    output rvex_pkg::t_mid_item o_q_data
);
    import rvex_pkg::*;

    logic                 accept;
    logic [MID_CNT_W-1:0] r_cnt;
    logic [MID_CNT_W-1:0] n_cnt;
    logic                 r_in_vld;
    t_in_item             r_in;
    logic                 r_vline [0:SC_LAT-1];
    t_in_item             r_cline [0:SC_LAT-1];
    t_trig                pitch_trig;
    t_trig                yaw_trig;
    t_trig                roll_trig;

    // Count transactions in flight here or waiting in the middle queue
    assign o_full = (r_cnt == MID_CNT_W'(MID_DEPTH));
    assign accept = i_push && !o_full;

    always_comb begin
        n_cnt = r_cnt;
        if (accept && !i_q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!accept && i_q_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_in_vld <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_item;
    end

    rvex_sincos u_pitch (.i_clk(i_clk), .i_angle(r_in.pitch_angle), .o_trig(pitch_trig));
    rvex_sincos u_yaw   (.i_clk(i_clk), .i_angle(r_in.yaw_angle),   .o_trig(yaw_trig));
    rvex_sincos u_roll  (.i_clk(i_clk), .i_angle(r_in.roll_angle),  .o_trig(roll_trig));

    // Delay valid and coordinates to line up with the trig results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SC_LAT; i++) begin
                r_vline[i] <= 1'b0;
            end
        end else begin
            r_vline[0] <= r_in_vld;
            for (int i = 1; i < SC_LAT; i++) begin
                r_vline[i] <= r_vline[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cline[0] <= r_in;
        for (int i = 1; i < SC_LAT; i++) begin
            r_cline[i] <= r_cline[i-1];
        end
    end

    assign o_q_push            = r_vline[SC_LAT-1];
    assign o_q_data.coord_x    = r_cline[SC_LAT-1].coord_x;
    assign o_q_data.coord_y    = r_cline[SC_LAT-1].coord_y;
    assign o_q_data.coord_z    = r_cline[SC_LAT-1].coord_z;
    assign o_q_data.pitch_trig = pitch_trig;
    assign o_q_data.yaw_trig   = yaw_trig;
    assign o_q_data.roll_trig  = roll_trig;

endmodule

// File: rtl/core/rvex_queue.sv
// Middle queue between front and back, first word visible while not empty.
// Depends on rvex_pkg; the front's credits guarantee it never overflows.
`timescale 1ns / 1ps
module rvex_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rvex_pkg::t_mid_item i_data,
    input  logic                i_pop,
    output logic                o_empty,
    output rvex_pkg::t_mid_item o_data
);
    import rvex_pkg::*;

    t_mid_item            r_mem [0:MID_DEPTH-1];
    logic [MID_PTR_W-1:0] r_wptr;
    logic [MID_PTR_W-1:0] r_rptr;
    logic [MID_CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    // Write storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rvex_back.sv
// Back end: three plane rotations, saturation and the result queue.
// Depends on rvex_pkg; pulls from the middle queue while result space remains.
`timescale 1ns / 1ps
module rvex_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  rvex_pkg::t_mid_item i_q_data,
    output logic                o_q_pop,
    output logic                o_empty,
    input  logic                i_pop,
    output rvex_pkg::t_out_item o_item
);
    import rvex_pkg::*;

    localparam logic signed [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << 29;
    localparam logic signed [WIDE_W-1:0] SAT_HI =
        WIDE_W'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - 1;

    logic                 out_pop;
    logic [OUT_CNT_W-1:0] r_credit;
    logic                 r_vld  [0:6];
    logic signed [WIDE_W-1:0] r_vec  [0:6][0:2];
    t_trig                r_trig [0:5][0:2];
    logic signed [PROD_W-1:0] r_prod [0:2][0:3];

    t_out_item            sat_item;
    logic [2:0]           sat_hit;
    logic signed [WIDE_W-1:0] sat_in [0:2];
    logic signed [COORD_WIDTH-1:0] sat_out [0:2];

    t_out_item            r_omem [0:OUT_DEPTH-1];
    logic [OUT_PTR_W-1:0] r_wptr;
    logic [OUT_PTR_W-1:0] r_rptr;
    logic [OUT_CNT_W-1:0] r_ocnt;

    // Take from the middle queue only while a result slot is reserved
    assign out_pop = i_pop && !o_empty;
    assign o_q_pop = !i_q_empty && (r_credit != OUT_CNT_W'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (o_q_pop && !out_pop) begin
            r_credit <= r_credit + 1'b1;
        end else if (!o_q_pop && out_pop) begin
            r_credit <= r_credit - 1'b1;
        end
    end

    // Valid chain through the rotation stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 7; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            r_vld[0] <= o_q_pop;
            for (int i = 1; i < 7; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    // Load the widened vector and the three trig sets
    always_ff @(posedge i_clk) begin
        r_vec[0][0]  <= WIDE_W'(i_q_data.coord_x);
        r_vec[0][1]  <= WIDE_W'(i_q_data.coord_y);
        r_vec[0][2]  <= WIDE_W'(i_q_data.coord_z);
        r_trig[0][0] <= i_q_data.pitch_trig;
        r_trig[0][1] <= i_q_data.yaw_trig;
        r_trig[0][2] <= i_q_data.roll_trig;
    end

    // Stage k rotates the plane of components A and B by angle k
    for (genvar k = 0; k < 3; k++) begin : g_plane
        localparam int A = (k + 1) % 3;
        localparam int B = (k + 2) % 3;

        logic signed [PROD_W:0] sum_p;
        logic signed [PROD_W:0] sum_q;

        // Multiply
        always_ff @(posedge i_clk) begin
            r_prod[k][0]   <= r_vec[2*k][A] * r_trig[2*k][k].cs;
            r_prod[k][1]   <= r_vec[2*k][B] * r_trig[2*k][k].sn;
            r_prod[k][2]   <= r_vec[2*k][A] * r_trig[2*k][k].sn;
            r_prod[k][3]   <= r_vec[2*k][B] * r_trig[2*k][k].cs;
            r_vec[2*k+1]   <= r_vec[2*k];
            r_trig[2*k+1]  <= r_trig[2*k];
        end

        // Add, round and scale back from Q30
        always_comb begin
            sum_p = (PROD_W + 1)'(r_prod[k][0]) - (PROD_W + 1)'(r_prod[k][1]) + RND_HALF;
            sum_q = (PROD_W + 1)'(r_prod[k][2]) + (PROD_W + 1)'(r_prod[k][3]) + RND_HALF;
        end

        always_ff @(posedge i_clk) begin
            if (r_trig[2*k+1][k].skip) begin
                r_vec[2*k+2] <= r_vec[2*k+1];
            end else begin
                r_vec[2*k+2][k] <= r_vec[2*k+1][k];
                r_vec[2*k+2][A] <= WIDE_W'(sum_p >>> 30);
                r_vec[2*k+2][B] <= WIDE_W'(sum_q >>> 30);
            end
        end

        if (k < 2) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_trig[2*k+2] <= r_trig[2*k+1];
            end
        end
    end

    // Clip each component to the coordinate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_in[i] = r_vec[6][i];
            if (sat_in[i] > SAT_HI) begin
                sat_out[i] = COORD_WIDTH'(SAT_HI);
                sat_hit[i] = 1'b1;
            end else if (sat_in[i] < SAT_LO) begin
                sat_out[i] = COORD_WIDTH'(SAT_LO);
                sat_hit[i] = 1'b1;
            end else begin
                sat_out[i] = COORD_WIDTH'(sat_in[i]);
                sat_hit[i] = 1'b0;
            end
        end
        sat_item.rotated_x = sat_out[0];
        sat_item.rotated_y = sat_out[1];
        sat_item.rotated_z = sat_out[2];
        sat_item.saturated = |sat_hit;
    end

    // Result queue
    assign o_empty = (r_ocnt == '0);
    assign o_item  = r_omem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (r_vld[6]) begin
            r_omem[r_wptr] <= sat_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_vld[6]) begin
                r_wptr <= (r_wptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (out_pop) begin
                r_rptr <= (r_rptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (r_vld[6] && !out_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (!r_vld[6] && out_pop) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/rotate_vector_euler_xyz_core.sv
// Euler XYZ vector rotator: one transaction per cycle sustained while results are popped without stalling.
// A pushed transaction passes the front pipeline, whose depth is set by the CORDIC
// step count, then the middle queue, the rotation stages and the result queue.
// Synchronous active-low reset empties both queues and all valid bits.
`timescale 1ns / 1ps
module rotate_vector_euler_xyz_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  rvex_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output rvex_pkg::t_out_item o_item
);
    import rvex_pkg::*;

    logic      q_push;
    logic      q_pop;
    logic      q_empty;
    t_mid_item q_wdata;
    t_mid_item q_rdata;

    rvex_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_q_pop  (q_pop),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    rvex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    rvex_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the Euler XYZ vector rotator core.
// Depends on rvex_pkg and rotate_vector_euler_xyz_core; predicts each result
// with its own CORDIC and fixed-point rotation and checks transactions in order.
`timescale 1ns / 1ps
module tb_top;
    import rvex_pkg::*;

    localparam int N_RANDOM   = 1850;
    localparam int DRAIN_WAIT = 60;
    localparam int WDOG_LIMIT = 5000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  i_item = '0;
    t_out_item o_item;

    t_in_item  pending_vecs[$];
    t_out_item rotated_expected[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        err_cnt = 0;
    int        sent_cnt = 0;
    int        recv_cnt = 0;
    int        sat_cnt = 0;
    int        quiet_cycles = 0;

    rotate_vector_euler_xyz_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_item (i_item),
        .empty  (empty),
        .pop    (pop),
        .o_item (o_item)
    );

    always #6 i_clk = ~i_clk;

    // Arctangent of 2^-i in Q30, rounded to nearest
    function automatic longint atan_step(input int i);
        longint tbl[16] = '{843314857, 497837829, 263043837, 133525159,
                            67021687, 33543516, 16775851, 8388437,
                            4194283, 2097149, 1048576, 524288,
                            262144, 131072, 65536, 32768};
        return tbl[i];
    endfunction

    // Sine and cosine in Q2.30 of a Q3.13 angle, by rotation-mode CORDIC
    function automatic void cordic_sin_cos(input longint raw, output longint sn,
                                           output longint cs);
        longint z;
        longint x;
        longint y;
        longint t;
        bit     flip;
        z = raw * (longint'(1) <<< (33 - ANGLE_WIDTH));
        x = 652032874;
        y = 0;
        flip = 1'b0;
        // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
        if (z > 64'sd3373259426) z -= 64'sd6746518852;
        else if (z < -64'sd3373259426) z += 64'sd6746518852;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_step(i);
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_step(i);
            end
            x = t;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    // (p*c + q*d + 2^29) >>> 30 at full precision
    function automatic longint mul_add_q30(input longint p, input longint c,
                                           input longint q, input longint d);
        logic signed [127:0] wp;
        logic signed [127:0] wc;
        logic signed [127:0] wq;
        logic signed [127:0] wd;
        logic signed [127:0] acc;
        wp = p;
        wc = c;
        wq = q;
        wd = d;
        acc = (wp * wc + wq * wd + (128'sd1 <<< 29)) >>> 30;
        return longint'(acc[63:0]);
    endfunction

    function automatic void rotate_plane(inout longint p, inout longint q,
                                         input longint raw);
        longint sn;
        longint cs;
        longint np;
        // zero angle passes the pair through untouched
        if (raw == 0) return;
        cordic_sin_cos(raw, sn, cs);
        np = mul_add_q30(p, cs, q, -sn);
        q = mul_add_q30(p, sn, q, cs);
        p = np;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] clip_coord(input longint v,
                                                          inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            v = hi;
            hit = 1'b1;
        end else if (v < lo) begin
            v = lo;
            hit = 1'b1;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic t_out_item rotate_euler_xyz(input t_in_item v);
        longint    x;
        longint    y;
        longint    z;
        bit        hit;
        t_out_item r;
        x = v.coord_x;
        y = v.coord_y;
        z = v.coord_z;
        hit = 1'b0;
        rotate_plane(y, z, longint'(v.pitch_angle));
        rotate_plane(z, x, longint'(v.yaw_angle));
        rotate_plane(x, y, longint'(v.roll_angle));
        r.rotated_x = clip_coord(x, hit);
        r.rotated_y = clip_coord(y, hit);
        r.rotated_z = clip_coord(z, hit);
        r.saturated = hit;
        return r;
    endfunction

    // Driver: record accepted transactions, then present the next vector
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                rotated_expected.push_back(rotate_euler_xyz(i_item));
                sent_cnt++;
            end
            if (!push || !full) begin
                if (pending_vecs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    push   <= 1'b1;
                    i_item <= pending_vecs.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each popped result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                recv_cnt++;
                if (rotated_expected.size() == 0) begin
                    $error("unexpected result x=%h y=%h z=%h", o_item.rotated_x,
                           o_item.rotated_y, o_item.rotated_z);
                    err_cnt++;
                end else begin
                    want = rotated_expected.pop_front();
                    if (want.saturated) sat_cnt++;
                    if (o_item.rotated_x !== want.rotated_x) begin
                        $error("rotated_x: expected %h, got %h", want.rotated_x,
                               o_item.rotated_x);
                        err_cnt++;
                    end
                    if (o_item.rotated_y !== want.rotated_y) begin
                        $error("rotated_y: expected %h, got %h", want.rotated_y,
                               o_item.rotated_y);
                        err_cnt++;
                    end
                    if (o_item.rotated_z !== want.rotated_z) begin
                        $error("rotated_z: expected %h, got %h", want.rotated_z,
                               o_item.rotated_z);
                        err_cnt++;
                    end
                    if (o_item.saturated !== want.saturated) begin
                        $error("saturated: expected %b, got %b", want.saturated,
                               o_item.saturated);
                        err_cnt++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [ANGLE_WIDTH-1:0] pick_angle();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return '0;
            // near the pi and half-pi folding points
            1: return 16'sd25736 - 16'($urandom_range(3));
            2: return -16'sd25736 + 16'($urandom_range(3));
            3: return 16'sd12868 - 16'($urandom_range(3));
            4: return -16'sd12868 + 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
        case ($urandom_range(3))
            0: return 32'($urandom_range(2097151)) - 32'sd1048576;
            1: return $urandom_range(1) ? 32'sh7fffffff - 32'($urandom_range(255))
                                        : 32'sh80000000 + 32'($urandom_range(255));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_vec(input logic signed [31:0] x, y, z,
                                          input logic signed [15:0] pa, ya, ra);
        t_in_item v;
        v.coord_x = x;
        v.coord_y = y;
        v.coord_z = z;
        v.pitch_angle = pa;
        v.yaw_angle = ya;
        v.roll_angle = ra;
        return v;
    endfunction

    task automatic drain_all();
        while (pending_vecs.size() > 0 || rotated_expected.size() > 0 || push)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    initial begin
        static int stall_sets[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{20, 20}};
        t_in_item v;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero angles, coordinate extremes, folding boundaries, saturation
        pending_vecs.push_back(make_vec(0, 0, 0, 0, 0, 0));
        pending_vecs.push_back(make_vec(32'sh7fffffff, 32'sh80000000, 32'sh12345678, 0, 0, 0));
        pending_vecs.push_back(make_vec(32'sh10000, 32'sh20000, 32'sh30000, 16'sh7fff, 0, 0));
        pending_vecs.push_back(make_vec(32'sh10000, 32'sh20000, 32'sh30000, 0, 16'sh8000, 0));
        pending_vecs.push_back(make_vec(32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 16'sh7fff));
        pending_vecs.push_back(make_vec(32'sh10000, -32'sh20000, 32'sh30000, 16'sh8000,
                                        16'sh8000, 16'sh8000));
        pending_vecs.push_back(make_vec(32'sh10000, 32'sh10000, 32'sh10000, 25735, 25736, -25736));
        pending_vecs.push_back(make_vec(32'sh10000, 32'sh10000, 32'sh10000, -25735, 12867, 12868));
        pending_vecs.push_back(make_vec(32'sh10000, 32'sh10000, 32'sh10000, -12868, -12867, 1));
        pending_vecs.push_back(make_vec(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                        6434, 6434, 6434));
        pending_vecs.push_back(make_vec(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                        6434, -6434, 6434));
        pending_vecs.push_back(make_vec(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                        -1, 16'sh7fff, 16'sh8000));
        pending_vecs.push_back(make_vec(32'sh80000000, 32'sh7fffffff, 0, 12868, 0, 25736));
        pending_vecs.push_back(make_vec(-1, 1, -1, 32767, -32768, 1));
        drain_all();

        // Random phases with different idle and stall rates; pause between them
        foreach (stall_sets[ph]) begin
            send_idle_pct  = stall_sets[ph][0];
            recv_stall_pct = stall_sets[ph][1];
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                v = make_vec(pick_coord(), pick_coord(), pick_coord(),
                             pick_angle(), pick_angle(), pick_angle());
                pending_vecs.push_back(v);
            end
            drain_all();
        end

        $display("Covered %0d vectors (%0d results, %0d saturated) across four idle/stall phases.",
                 sent_cnt, recv_cnt, sat_cnt);
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
